>>> design/nrv_pkg.sv
package nrv_pkg;

    // Number of robots in the formation and derived index widths.
    localparam int ROBOTS = 8;
    localparam int IDX_W  = $clog2(ROBOTS);
    localparam int CNT_W  = $clog2(ROBOTS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ROBOTS - 1);

    // Datapath widths.
    localparam int W_W   = 17;            // weight, unsigned Q.16
    localparam int SUM_W = W_W + IDX_W;   // sum of weights
    localparam int ACC_W = 40;            // multiply-accumulate register
    localparam int NUM_W = 40;            // divider numerator
    localparam int DEN_W = 25;            // divider denominator
    localparam int SQI_W = 50;            // square-root radicand
    localparam int SQR_W = 25;            // square root

    // Serial step counts (last step index).
    localparam logic [5:0] MUL_LAST  = 6'(W_W - 1);
    localparam logic [5:0] SQRT_LAST = 6'(SQR_W - 1);
    localparam logic [5:0] DIV_LAST  = 6'(NUM_W - 1);

    // Weight of one, Q.16.
    localparam logic [W_W-1:0] ONE_Q16 = W_W'(65536);

    // Configuration register indexes.
    localparam logic [1:0] CFG_SELF = 2'd0;
    localparam logic [1:0] CFG_FAR  = 2'd1;
    localparam logic [1:0] CFG_NEAR = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FSQ,
        ST_NSQ,
        ST_CAP_SELF,
        ST_RD,
        ST_CAP,
        ST_MDX,
        ST_MDY,
        ST_CMP,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_WGT,
        ST_WDIV,
        ST_POST,
        ST_NORM,
        ST_MAC,
        ST_FINAL
    } state_t;

endpackage

>>> design/neighbor_repulsion_vector_top.sv
// Neighbor repulsion vector.
// Input items arrive on start/busy: an item is taken at a clock edge with start
// high and busy low. Each item stores pos_x/pos_y in the next free slot; an item
// with is_last set also carries start_dir_x/start_dir_y and starts the compute.
// Configuration registers are written through cfg_valid/cfg_ready, with
// cfg_index selecting self_index, far_limit or near_limit; cfg_ready is always
// high. Writes are to be made only while the block is idle; the block does not enforce this.
// A position item leaves busy low. A last item keeps busy high while each robot
// other than self_index runs through a bit-serial multiplier; one within the far
// limit also runs through a two-bit-per-cycle square root and, unless coincident,
// a one-bit-per-cycle restoring divider; then every weight is normalized when the
// weights sum above one, and every weight is multiplied twice.
// The result is shown on dir_x, dir_y and saturated, marked by done high for
// exactly one cycle in the same cycle that busy falls; the receiver cannot stall
// it, and a new item may be taken in that same cycle.
// Reset clears the slot count and loads the configuration defaults; the position
// slots hold no value until written.
module neighbor_repulsion_vector_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [19:0] start_dir_x,
    input  logic signed [19:0] start_dir_y,
    input  logic               is_last,
    output logic               done,
    output logic signed [19:0] dir_x,
    output logic signed [19:0] dir_y,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    localparam int IDX_W = nrv_pkg::IDX_W;
    localparam int W_W   = nrv_pkg::W_W;
    localparam int SUM_W = nrv_pkg::SUM_W;
    localparam int ACC_W = nrv_pkg::ACC_W;
    localparam int NUM_W = nrv_pkg::NUM_W;
    localparam int DEN_W = nrv_pkg::DEN_W;
    localparam int SQI_W = nrv_pkg::SQI_W;
    localparam int SQR_W = nrv_pkg::SQR_W;
    localparam int CNT_W = nrv_pkg::CNT_W;

    nrv_pkg::state_t state_reg, state_next;

    logic [5:0]        self_reg;
    logic [14:0]       far_reg, near_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [5:0]        step_reg, step_next;
    logic              axis_reg, axis_next;

    // Position store and its registered read port.
    logic [31:0]       store [nrv_pkg::ROBOTS];
    logic [31:0]       rd_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;

    logic signed [15:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [16:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [29:0]        far_sq_reg, far_sq_next, near_sq_reg, near_sq_next;
    logic [33:0]        dsq_reg, dsq_next;
    logic [SQR_W-1:0]   dfine_reg, dfine_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [19:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [ACC_W-1:0] subx_reg, subx_next, suby_reg, suby_next;

    // Per-robot weights and unit vectors.
    logic [W_W-1:0]     w_reg [nrv_pkg::ROBOTS];
    logic signed [15:0] ux_reg [nrv_pkg::ROBOTS];
    logic signed [15:0] uy_reg [nrv_pkg::ROBOTS];
    logic               w_we, ux_we, uy_we;
    logic [W_W-1:0]     w_wd;
    logic signed [15:0] ux_wd, uy_wd;

    // Serial multiplier.
    logic signed [ACC_W-1:0] mcand_reg, mcand_next, acc_reg, acc_next, acc_step;
    logic [W_W-1:0]          mplier_reg, mplier_next;

    // Serial square root.
    logic [SQI_W-1:0]   sq_in_reg, sq_in_next;
    logic [25:0]        sq_rem_reg, sq_rem_next, sq_rem_step;
    logic [SQR_W-1:0]   sq_root_reg, sq_root_next, sq_root_step;
    logic [27:0]        sq_r, sq_trial, sq_diff;

    // Serial divider.
    logic [NUM_W-1:0]   dv_num_reg, dv_num_next, dv_q_reg, dv_q_next, dv_q_step;
    logic [DEN_W-1:0]   dv_den_reg, dv_den_next, dv_rem_reg, dv_rem_next, dv_rem_step;
    logic [DEN_W:0]     dv_r, dv_diff;
    logic               dv_ge;

    // Output registers.
    logic               done_reg, done_next;
    logic signed [19:0] dir_x_reg, dir_x_next, dir_y_reg, dir_y_next;
    logic               sat_reg, sat_next;

    // Helper values.
    logic [16:0]        dx_mag, dy_mag, cap_dx_mag, cap_dy_mag;
    logic signed [16:0] cap_dx, cap_dy;
    logic [24:0]        wnum;
    logic [IDX_W-1:0]   idx_inc;
    logic               self_ok, at_self;
    logic signed [ACC_W-1:0] sub_sel;
    logic [ACC_W-1:0]   sub_mag;
    logic [ACC_W-1:0]   sub_rnd;
    logic signed [25:0] rq, rx, ry;

    assign busy      = (state_reg != nrv_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign dir_x     = dir_x_reg;
    assign dir_y     = dir_y_reg;
    assign saturated = sat_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_reg <= 6'd0;
            far_reg  <= 15'd256;
            near_reg <= 15'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nrv_pkg::CFG_SELF: self_reg <= cfg_data[5:0];
                nrv_pkg::CFG_FAR:  far_reg  <= cfg_data;
                nrv_pkg::CFG_NEAR: near_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Position memory: write on a taken item, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[cnt_reg[IDX_W-1:0]] <= {pos_y, pos_x};
        end
        rd_reg <= store[rd_addr];
    end

    // Per-robot weight and unit vector registers.
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_reg[idx_reg] <= w_wd;
        end
        if (ux_we)
        begin
            ux_reg[idx_reg] <= ux_wd;
        end
        if (uy_we)
        begin
            uy_reg[idx_reg] <= uy_wd;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrv_pkg::ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            axis_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            axis_reg  <= axis_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        far_sq_reg  <= far_sq_next;
        near_sq_reg <= near_sq_next;
        dsq_reg     <= dsq_next;
        dfine_reg   <= dfine_next;
        sum_reg     <= sum_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        subx_reg    <= subx_next;
        suby_reg    <= suby_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        acc_reg     <= acc_next;
        sq_in_reg   <= sq_in_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        dv_num_reg  <= dv_num_next;
        dv_den_reg  <= dv_den_next;
        dv_rem_reg  <= dv_rem_next;
        dv_q_reg    <= dv_q_next;
        dir_x_reg   <= dir_x_next;
        dir_y_reg   <= dir_y_next;
        sat_reg     <= sat_next;
    end

    // One step of each serial unit.
    always_comb
    begin
        acc_step = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

        sq_r     = {sq_rem_reg, sq_in_reg[SQI_W-1:SQI_W-2]};
        sq_trial = {1'b0, sq_root_reg, 2'b01};
        sq_diff  = sq_r - sq_trial;
        if (sq_r >= sq_trial)
        begin
            sq_rem_step  = sq_diff[25:0];
            sq_root_step = {sq_root_reg[SQR_W-2:0], 1'b1};
        end
        else
        begin
            sq_rem_step  = sq_r[25:0];
            sq_root_step = {sq_root_reg[SQR_W-2:0], 1'b0};
        end

        dv_r        = {dv_rem_reg, dv_num_reg[NUM_W-1]};
        dv_diff     = dv_r - {1'b0, dv_den_reg};
        dv_ge       = (dv_r >= {1'b0, dv_den_reg});
        dv_rem_step = dv_ge ? dv_diff[DEN_W-1:0] : dv_r[DEN_W-1:0];
        dv_q_step   = {dv_q_reg[NUM_W-2:0], dv_ge};
    end

    // Helper values for the sequencer.
    always_comb
    begin
        dx_mag     = dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
        dy_mag     = dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg);
        cap_dx     = 17'(signed'(rd_reg[15:0])) - 17'(ox_reg);
        cap_dy     = 17'(signed'(rd_reg[31:16])) - 17'(oy_reg);
        cap_dx_mag = cap_dx[16] ? 17'(-cap_dx) : 17'(cap_dx);
        cap_dy_mag = cap_dy[16] ? 17'(-cap_dy) : 17'(cap_dy);
        wnum       = {2'b00, far_reg, 8'd0} - dfine_reg;
        idx_inc    = idx_reg + 1'b1;
        self_ok    = (32'(self_reg) < nrv_pkg::ROBOTS);
        at_self    = (self_reg[IDX_W-1:0] == idx_reg);
        sub_sel    = axis_reg ? suby_reg : subx_reg;
        sub_mag    = sub_sel[ACC_W-1] ? ACC_W'(-sub_sel) : ACC_W'(sub_sel);
        sub_rnd    = (sub_mag + ACC_W'(32768)) >> 16;
        rq         = sub_sel[ACC_W-1] ? -26'(sub_rnd[24:0]) : 26'(sub_rnd[24:0]);
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        axis_next    = axis_reg;
        done_next    = 1'b0;
        rd_addr      = idx_reg;
        wr_en        = 1'b0;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        far_sq_next  = far_sq_reg;
        near_sq_next = near_sq_reg;
        dsq_next     = dsq_reg;
        dfine_next   = dfine_reg;
        sum_next     = sum_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        subx_next    = subx_reg;
        suby_next    = suby_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        acc_next     = acc_reg;
        sq_in_next   = sq_in_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        dv_num_next  = dv_num_reg;
        dv_den_next  = dv_den_reg;
        dv_rem_next  = dv_rem_reg;
        dv_q_next    = dv_q_reg;
        dir_x_next   = dir_x_reg;
        dir_y_next   = dir_y_reg;
        sat_next     = sat_reg;
        w_we         = 1'b0;
        ux_we        = 1'b0;
        uy_we        = 1'b0;
        w_wd         = '0;
        ux_wd        = '0;
        uy_wd        = '0;
        rx           = '0;
        ry           = '0;

        case (state_reg)
            nrv_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (32'(cnt_reg) < nrv_pkg::ROBOTS)
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (is_last)
                    begin
                        cnt_next    = '0;
                        sx_next     = start_dir_x;
                        sy_next     = start_dir_y;
                        mcand_next  = ACC_W'(far_reg);
                        mplier_next = W_W'(far_reg);
                        acc_next    = '0;
                        step_next   = '0;
                        state_next  = nrv_pkg::ST_FSQ;
                    end
                end
            end

            // Squares of the two limits.
            nrv_pkg::ST_FSQ:
            begin
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                acc_next    = acc_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::MUL_LAST)
                begin
                    far_sq_next = acc_step[29:0];
                    mcand_next  = ACC_W'(near_reg);
                    mplier_next = W_W'(near_reg);
                    acc_next    = '0;
                    step_next   = '0;
                    state_next  = nrv_pkg::ST_NSQ;
                end
            end

            nrv_pkg::ST_NSQ:
            begin
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                acc_next    = acc_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::MUL_LAST)
                begin
                    near_sq_next = acc_step[29:0];
                    rd_addr      = self_reg[IDX_W-1:0];
                    sum_next     = '0;
                    if (self_ok)
                    begin
                        state_next = nrv_pkg::ST_CAP_SELF;
                    end
                    else
                    begin
                        // No robot is weighted: the start direction passes through.
                        subx_next  = '0;
                        suby_next  = '0;
                        axis_next  = 1'b0;
                        state_next = nrv_pkg::ST_FINAL;
                    end
                end
            end

            nrv_pkg::ST_CAP_SELF:
            begin
                ox_next    = signed'(rd_reg[15:0]);
                oy_next    = signed'(rd_reg[31:16]);
                idx_next   = '0;
                state_next = nrv_pkg::ST_RD;
            end

            // Read robot idx; its own robot is skipped with zero weight.
            nrv_pkg::ST_RD:
            begin
                if (at_self)
                begin
                    w_we  = 1'b1;
                    ux_we = 1'b1;
                    uy_we = 1'b1;
                    if (idx_reg == nrv_pkg::IDX_LAST)
                    begin
                        state_next = nrv_pkg::ST_POST;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                else
                begin
                    state_next = nrv_pkg::ST_CAP;
                end
            end

            nrv_pkg::ST_CAP:
            begin
                dx_next     = cap_dx;
                dy_next     = cap_dy;
                mcand_next  = ACC_W'(cap_dx_mag);
                mplier_next = cap_dx_mag;
                acc_next    = '0;
                step_next   = '0;
                state_next  = nrv_pkg::ST_MDX;
            end

            // Squared distance, dx*dx then dy*dy into the same accumulator.
            nrv_pkg::ST_MDX:
            begin
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                acc_next    = acc_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::MUL_LAST)
                begin
                    mcand_next  = ACC_W'(dy_mag);
                    mplier_next = dy_mag;
                    step_next   = '0;
                    state_next  = nrv_pkg::ST_MDY;
                end
            end

            nrv_pkg::ST_MDY:
            begin
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                acc_next    = acc_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::MUL_LAST)
                begin
                    dsq_next   = acc_step[33:0];
                    state_next = nrv_pkg::ST_CMP;
                end
            end

            // Beyond the far limit the robot is ignored.
            nrv_pkg::ST_CMP:
            begin
                if (dsq_reg > 34'(far_sq_reg))
                begin
                    w_we  = 1'b1;
                    ux_we = 1'b1;
                    uy_we = 1'b1;
                    if (idx_reg == nrv_pkg::IDX_LAST)
                    begin
                        state_next = nrv_pkg::ST_POST;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = nrv_pkg::ST_RD;
                    end
                end
                else
                begin
                    sq_in_next   = {dsq_reg, 16'd0};
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    step_next    = '0;
                    state_next   = nrv_pkg::ST_SQRT;
                end
            end

            // Fine distance, two radicand bits per cycle.
            nrv_pkg::ST_SQRT:
            begin
                sq_in_next   = sq_in_reg << 2;
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                step_next    = step_reg + 1'b1;
                if (step_reg == nrv_pkg::SQRT_LAST)
                begin
                    dfine_next = sq_root_step;
                    step_next  = '0;
                    if (sq_root_step == '0)
                    begin
                        // Coincident robots add weight but no displacement.
                        ux_we      = 1'b1;
                        uy_we      = 1'b1;
                        state_next = nrv_pkg::ST_WGT;
                    end
                    else
                    begin
                        dv_num_next = {1'b0, dx_mag, 22'd0} + NUM_W'(sq_root_step[SQR_W-1:1]);
                        dv_den_next = sq_root_step;
                        dv_rem_next = '0;
                        state_next  = nrv_pkg::ST_DIVX;
                    end
                end
            end

            // Unit vector components, rounded to nearest.
            nrv_pkg::ST_DIVX:
            begin
                dv_num_next = dv_num_reg << 1;
                dv_rem_next = dv_rem_step;
                dv_q_next   = dv_q_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::DIV_LAST)
                begin
                    ux_we       = 1'b1;
                    ux_wd       = dx_reg[16] ? -16'(dv_q_step[15:0]) : 16'(dv_q_step[15:0]);
                    dv_num_next = {1'b0, dy_mag, 22'd0} + NUM_W'(dfine_reg[SQR_W-1:1]);
                    dv_rem_next = '0;
                    step_next   = '0;
                    state_next  = nrv_pkg::ST_DIVY;
                end
            end

            nrv_pkg::ST_DIVY:
            begin
                dv_num_next = dv_num_reg << 1;
                dv_rem_next = dv_rem_step;
                dv_q_next   = dv_q_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::DIV_LAST)
                begin
                    uy_we      = 1'b1;
                    uy_wd      = dy_reg[16] ? -16'(dv_q_step[15:0]) : 16'(dv_q_step[15:0]);
                    step_next  = '0;
                    state_next = nrv_pkg::ST_WGT;
                end
            end

            // Full weight below the near limit or when far is not above near, else the linear band.
            nrv_pkg::ST_WGT:
            begin
                if ((dsq_reg < 34'(near_sq_reg)) || (far_reg <= near_reg))
                begin
                    w_we     = 1'b1;
                    w_wd     = nrv_pkg::ONE_Q16;
                    sum_next = sum_reg + SUM_W'(nrv_pkg::ONE_Q16);
                    if (idx_reg == nrv_pkg::IDX_LAST)
                    begin
                        state_next = nrv_pkg::ST_POST;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = nrv_pkg::ST_RD;
                    end
                end
                else
                begin
                    dv_num_next = {wnum[23:0], 16'd0}
                                + NUM_W'({15'(far_reg - near_reg), 7'd0});
                    dv_den_next = {2'b00, 15'(far_reg - near_reg), 8'd0};
                    dv_rem_next = '0;
                    step_next   = '0;
                    state_next  = nrv_pkg::ST_WDIV;
                end
            end

            nrv_pkg::ST_WDIV:
            begin
                dv_num_next = dv_num_reg << 1;
                dv_rem_next = dv_rem_step;
                dv_q_next   = dv_q_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::DIV_LAST)
                begin
                    w_we      = 1'b1;
                    w_wd      = dv_q_step[W_W-1:0];
                    sum_next  = sum_reg + SUM_W'(dv_q_step[W_W-1:0]);
                    step_next = '0;
                    if (idx_reg == nrv_pkg::IDX_LAST)
                    begin
                        state_next = nrv_pkg::ST_POST;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = nrv_pkg::ST_RD;
                    end
                end
            end

            // Normalize when the weights sum above one.
            nrv_pkg::ST_POST:
            begin
                idx_next  = '0;
                step_next = '0;
                if (sum_reg > SUM_W'(nrv_pkg::ONE_Q16))
                begin
                    dv_num_next = NUM_W'({w_reg[0], 16'd0}) + NUM_W'(sum_reg[SUM_W-1:1]);
                    dv_den_next = DEN_W'(sum_reg);
                    dv_rem_next = '0;
                    state_next  = nrv_pkg::ST_NORM;
                end
                else
                begin
                    axis_next   = 1'b0;
                    acc_next    = '0;
                    mcand_next  = ACC_W'(ux_reg[0]);
                    mplier_next = w_reg[0];
                    state_next  = nrv_pkg::ST_MAC;
                end
            end

            nrv_pkg::ST_NORM:
            begin
                dv_num_next = dv_num_reg << 1;
                dv_rem_next = dv_rem_step;
                dv_q_next   = dv_q_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::DIV_LAST)
                begin
                    w_we      = 1'b1;
                    w_wd      = dv_q_step[W_W-1:0];
                    step_next = '0;
                    if (idx_reg == nrv_pkg::IDX_LAST)
                    begin
                        idx_next    = '0;
                        axis_next   = 1'b0;
                        acc_next    = '0;
                        mcand_next  = ACC_W'(ux_reg[0]);
                        mplier_next = (IDX_W'(0) == idx_reg) ? dv_q_step[W_W-1:0] : w_reg[0];
                        state_next  = nrv_pkg::ST_MAC;
                    end
                    else
                    begin
                        idx_next    = idx_inc;
                        dv_num_next = NUM_W'({w_reg[idx_inc], 16'd0})
                                    + NUM_W'(sum_reg[SUM_W-1:1]);
                        dv_rem_next = '0;
                    end
                end
            end

            // Weighted sum of unit vectors, x pass then y pass.
            nrv_pkg::ST_MAC:
            begin
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                acc_next    = acc_step;
                step_next   = step_reg + 1'b1;
                if (step_reg == nrv_pkg::MUL_LAST)
                begin
                    step_next = '0;
                    if (idx_reg == nrv_pkg::IDX_LAST)
                    begin
                        idx_next = '0;
                        if (!axis_reg)
                        begin
                            subx_next   = acc_step;
                            axis_next   = 1'b1;
                            acc_next    = '0;
                            mcand_next  = ACC_W'(uy_reg[0]);
                            mplier_next = w_reg[0];
                        end
                        else
                        begin
                            suby_next  = acc_step;
                            axis_next  = 1'b0;
                            state_next = nrv_pkg::ST_FINAL;
                        end
                    end
                    else
                    begin
                        idx_next    = idx_inc;
                        mcand_next  = axis_reg ? ACC_W'(uy_reg[idx_inc]) : ACC_W'(ux_reg[idx_inc]);
                        mplier_next = w_reg[idx_inc];
                    end
                end
            end

            // Round, subtract and clamp, one component per cycle.
            nrv_pkg::ST_FINAL:
            begin
                if (!axis_reg)
                begin
                    rx = 26'(sx_reg) - rq;
                    if (rx > 26'sd524287)
                    begin
                        dir_x_next = 20'sd524287;
                        sat_next   = 1'b1;
                    end
                    else if (rx < -26'sd524288)
                    begin
                        dir_x_next = -20'sd524288;
                        sat_next   = 1'b1;
                    end
                    else
                    begin
                        dir_x_next = rx[19:0];
                        sat_next   = 1'b0;
                    end
                    axis_next = 1'b1;
                end
                else
                begin
                    ry = 26'(sy_reg) - rq;
                    if (ry > 26'sd524287)
                    begin
                        dir_y_next = 20'sd524287;
                        sat_next   = 1'b1;
                    end
                    else if (ry < -26'sd524288)
                    begin
                        dir_y_next = -20'sd524288;
                        sat_next   = 1'b1;
                    end
                    else
                    begin
                        dir_y_next = ry[19:0];
                    end
                    axis_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = nrv_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nrv_pkg::ST_IDLE;
            end
        endcase
    end

    // A result only follows the last rounding step.
    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == nrv_pkg::ST_FINAL))
        else $error("done without a finished compute");

    // The slot count never passes the formation size.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= nrv_pkg::ROBOTS)
        else $error("slot count out of range");

    // Weights never sum above what the robots can give.
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nrv_pkg::ST_POST) |-> (32'(sum_reg) <= (nrv_pkg::ROBOTS - 1) * 65536))
        else $error("weight sum out of range");

    // A last item always starts the compute.
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_last) |=> (state_reg == nrv_pkg::ST_FSQ))
        else $error("last item did not start the compute");

endmodule
